// ===== design/conv1d_same_pad_relu_defines.svh =====
// ----------------------------------------------------------------------------
// conv1d_same_pad_relu_defines
// Assertion macros shared by the convolution filter RTL.
// ----------------------------------------------------------------------------
`ifndef CONV1D_SAME_PAD_RELU_DEFINES_SVH
`define CONV1D_SAME_PAD_RELU_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define C1D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while in reset.
`define C1D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/c1d_pkg.sv =====
// ----------------------------------------------------------------------------
// c1d_pkg
// Shared constants, types and the job format of the convolution filter.
// ----------------------------------------------------------------------------
package c1d_pkg;

    localparam int TAPS      = 7;
    localparam int LEFT      = TAPS / 2;
    localparam int LAG       = TAPS - 1 - LEFT;
    localparam int WIN       = TAPS - 1;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int VALUE_W   = 15;
    localparam int FILL_W    = 3;
    localparam int J_W       = (LAG > 0) ? $clog2(LAG + 1) : 1;
    localparam int EXT_IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SEL_W     = EXT_IDX_W + 1;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int BIAS_SH   = 14;
    localparam int ACC_W     = PROD_W + 3;
    localparam int NTERM     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int RND_SH    = 14;
    localparam int RND_ADD   = 1 << (RND_SH - 1);
    localparam int VALUE_MAX = (1 << VALUE_W) - 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS   = 3'd7;

    typedef logic [TAPS-1:0][SAMPLE_W-1:0] ext_t;
    typedef logic [TAPS-1:0][COEF_W-1:0]   coef_arr_t;

    // one unit of work for the back end: a window snapshot and the span of
    // output positions it produces
    typedef struct packed {
        ext_t           ext;
        logic [J_W-1:0] jfirst;
        logic           frame_end;
    } job_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
    } fr_stat_t;

endpackage

// ===== design/c1d_in_if.sv =====
// ----------------------------------------------------------------------------
// c1d_in_if
// Sample stream channel: valid/ready handshake with sample and frame flag.
// ----------------------------------------------------------------------------
interface c1d_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [c1d_pkg::SAMPLE_W-1:0]     sample;
    logic                                    frame_end;

    modport source (output valid, output sample, output frame_end, input ready);
    modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

// ===== design/c1d_out_if.sv =====
// ----------------------------------------------------------------------------
// c1d_out_if
// Result stream channel: valid/ready handshake with value and last flag.
// ----------------------------------------------------------------------------
interface c1d_out_if;
    logic                          valid;
    logic                          ready;
    logic [c1d_pkg::VALUE_W-1:0]   value;
    logic                          last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== design/c1d_front.sv =====
// ----------------------------------------------------------------------------
// c1d_front
// Accepts samples, keeps the window and fill count, and emits jobs.
// ----------------------------------------------------------------------------
module c1d_front (
    input  logic                clk,
    input  logic                rst_n,
    c1d_in_if.sink              samples,
    input  c1d_pkg::q_stat_t    q_stat,
    output logic                push,
    output c1d_pkg::job_t       job,
    output c1d_pkg::fr_stat_t   fr_stat
);

    logic [c1d_pkg::WIN-1:0][c1d_pkg::SAMPLE_W-1:0] win_reg, win_next;
    logic [c1d_pkg::FILL_W-1:0]                     fill_reg, fill_next;
    logic                                           accept;
    logic                                           primed;

    assign samples.ready = !q_stat.full;
    assign accept        = samples.valid && samples.ready;
    assign primed        = fill_reg >= c1d_pkg::FILL_W'(c1d_pkg::LAG);
    assign fr_stat.fill  = fill_reg;

    // job: window plus the new sample, and the first output position
    always_comb
    begin
        for (int i = 0; i < c1d_pkg::WIN; i++)
        begin
            job.ext[i] = win_reg[i];
        end
        job.ext[c1d_pkg::TAPS-1] = samples.sample;
        job.frame_end            = samples.frame_end;
        if (primed || !samples.frame_end)
        begin
            job.jfirst = '0;
        end
        else
        begin
            job.jfirst = c1d_pkg::J_W'(c1d_pkg::LAG) - c1d_pkg::J_W'(fill_reg);
        end
        push = accept && (samples.frame_end || primed);
    end

    // shift the window, or drop it at the end of a frame
    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            if (samples.frame_end)
            begin
                win_next  = '0;
                fill_next = '0;
            end
            else
            begin
                for (int i = 0; i < c1d_pkg::WIN - 1; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[c1d_pkg::WIN-1] = samples.sample;
                if (fill_reg < c1d_pkg::FILL_W'(c1d_pkg::WIN))
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            win_reg  <= win_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== design/c1d_queue.sv =====
// ----------------------------------------------------------------------------
// c1d_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module c1d_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  c1d_pkg::job_t      push_job,
    input  logic               pop,
    output c1d_pkg::job_t      head,
    output c1d_pkg::q_stat_t   q_stat
);

    c1d_pkg::job_t                 mem [c1d_pkg::QDEPTH];
    logic [c1d_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [c1d_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [c1d_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    assign q_stat.count = count_reg;
    assign q_stat.full  = count_reg == c1d_pkg::QCNT_W'(c1d_pkg::QDEPTH);
    assign q_stat.empty = count_reg == '0;
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == c1d_pkg::QPTR_W'(c1d_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == c1d_pkg::QPTR_W'(c1d_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/c1d_back.sv =====
// ----------------------------------------------------------------------------
// c1d_back
// Walks each job's output positions and runs the multiply-add pipeline.
// ----------------------------------------------------------------------------
module c1d_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  c1d_pkg::job_t        head,
    input  c1d_pkg::q_stat_t     q_stat,
    output logic                 pop,
    input  c1d_pkg::coef_arr_t   coef,
    input  logic [c1d_pkg::COEF_W-1:0] bias,
    c1d_out_if.source            results
);

    localparam int SUM4 = c1d_pkg::NTERM / 2;
    localparam int SUM2 = c1d_pkg::NTERM / 4;

    // sequencer
    logic                       busy_reg, busy_next;
    logic [c1d_pkg::J_W-1:0]    j_reg, j_next;
    logic [c1d_pkg::J_W-1:0]    jcur;
    logic [c1d_pkg::J_W-1:0]    jlast;
    logic                       done;
    logic                       issue;
    logic                       adv;

    // pipeline stages
    logic                                          a_valid_reg, b_valid_reg, c_valid_reg;
    logic                                          d_valid_reg, e_valid_reg, out_valid_reg;
    logic                                          a_last_reg, b_last_reg, c_last_reg;
    logic                                          d_last_reg, e_last_reg, out_last_reg;
    c1d_pkg::ext_t                                 a_tap_reg, a_tap_next;
    logic signed [c1d_pkg::ACC_W-1:0]              b_term_reg [c1d_pkg::NTERM];
    logic signed [c1d_pkg::ACC_W-1:0]              c_sum_reg  [SUM4];
    logic signed [c1d_pkg::ACC_W-1:0]              d_sum_reg  [SUM2];
    logic signed [c1d_pkg::ACC_W-1:0]              e_total_reg;
    logic signed [c1d_pkg::ACC_W-1:0]              rounded;
    logic [c1d_pkg::VALUE_W-1:0]                   out_value_reg, out_value_next;
    logic [c1d_pkg::SEL_W-1:0]                     sel;

    assign adv   = !out_valid_reg || results.ready;
    assign jcur  = busy_reg ? j_reg : head.jfirst;
    assign jlast = head.frame_end ? c1d_pkg::J_W'(c1d_pkg::LAG) : '0;
    assign done  = jcur == jlast;
    assign issue = adv && !q_stat.empty;
    assign pop   = issue && done;

    always_comb
    begin
        busy_next = busy_reg;
        j_next    = j_reg;
        if (issue)
        begin
            busy_next = !done;
            j_next    = jcur + 1'b1;
        end
    end

    // shifted window with zero right padding
    always_comb
    begin
        sel = '0;
        for (int k = 0; k < c1d_pkg::TAPS; k++)
        begin
            sel = c1d_pkg::SEL_W'(k) + c1d_pkg::SEL_W'(jcur);
            if (sel < c1d_pkg::SEL_W'(c1d_pkg::TAPS))
            begin
                a_tap_next[k] = head.ext[sel[c1d_pkg::EXT_IDX_W-1:0]];
            end
            else
            begin
                a_tap_next[k] = '0;
            end
        end
    end

    // round, ReLU and saturate
    always_comb
    begin
        rounded = (e_total_reg + c1d_pkg::ACC_W'(c1d_pkg::RND_ADD)) >>> c1d_pkg::RND_SH;
        if (e_total_reg <= 0)
        begin
            out_value_next = '0;
        end
        else if (rounded > c1d_pkg::ACC_W'(c1d_pkg::VALUE_MAX))
        begin
            out_value_next = c1d_pkg::VALUE_W'(c1d_pkg::VALUE_MAX);
        end
        else
        begin
            out_value_next = rounded[c1d_pkg::VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            j_reg         <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            j_reg    <= j_next;
            if (adv)
            begin
                a_valid_reg   <= issue;
                b_valid_reg   <= a_valid_reg;
                c_valid_reg   <= b_valid_reg;
                d_valid_reg   <= c_valid_reg;
                e_valid_reg   <= d_valid_reg;
                out_valid_reg <= e_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_tap_reg  <= a_tap_next;
            a_last_reg <= head.frame_end && done;

            for (int k = 0; k < c1d_pkg::NTERM - 1; k++)
            begin
                if (k < c1d_pkg::TAPS)
                begin
                    b_term_reg[k] <= c1d_pkg::ACC_W'($signed(a_tap_reg[k]) *
                                                     $signed(coef[k]));
                end
                else
                begin
                    b_term_reg[k] <= '0;
                end
            end
            b_term_reg[c1d_pkg::NTERM-1] <=
                c1d_pkg::ACC_W'($signed(bias)) <<< c1d_pkg::BIAS_SH;
            b_last_reg <= a_last_reg;

            for (int i = 0; i < SUM4; i++)
            begin
                c_sum_reg[i] <= b_term_reg[2*i] + b_term_reg[2*i+1];
            end
            c_last_reg <= b_last_reg;

            for (int i = 0; i < SUM2; i++)
            begin
                d_sum_reg[i] <= c_sum_reg[2*i] + c_sum_reg[2*i+1];
            end
            d_last_reg <= c_last_reg;

            e_total_reg <= d_sum_reg[0] + d_sum_reg[1];
            e_last_reg  <= d_last_reg;

            out_value_reg <= out_value_next;
            out_last_reg  <= e_last_reg;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.value = out_value_reg;
    assign results.last  = out_last_reg;

endmodule

// ===== design/conv1d_same_pad_relu.sv =====
// ----------------------------------------------------------------------------
// conv1d_same_pad_relu
// Seven-tap 1-D convolution filter with same zero padding, bias and ReLU.
// ----------------------------------------------------------------------------
//
//   channel    dir   handshake        payload
//   samples    in    valid / ready    sample (s16, Q4.11), frame_end
//   results    out   valid / ready    value (u15, Q4.11), last
//   cfg        in    cfg_we           cfg_index (3b), cfg_data (16b)
//
// A sample is taken each cycle the two-entry queue has room; a frame-end sample
// yields up to four words, one a cycle while results is not stalled.
// After its sample is taken, a word passes the queue, tap select, multiply,
// three adder levels and the round/saturate register.
// Reset clears window, fill count, queue, pipeline valids and configuration registers.
// A stall on results freezes the back end; samples keep coming until the queue fills.
//
module conv1d_same_pad_relu (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [c1d_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [c1d_pkg::CFG_W-1:0]          cfg_data,
    c1d_in_if.sink                             samples,
    c1d_out_if.source                          results
);

`include "conv1d_same_pad_relu_defines.svh"

    // configuration registers
    c1d_pkg::coef_arr_t               coef_reg, coef_next;
    logic [c1d_pkg::COEF_W-1:0]       bias_reg, bias_next;

    // front to queue to back
    logic                             push;
    logic                             pop;
    c1d_pkg::job_t                    push_job;
    c1d_pkg::job_t                    head;
    c1d_pkg::q_stat_t                 q_stat;
    c1d_pkg::fr_stat_t                fr_stat;

    // decode a write; indexes past the taps other than the bias are dropped
    always_comb
    begin
        coef_next = coef_reg;
        bias_next = bias_reg;
        if (cfg_we)
        begin
            for (int k = 0; k < c1d_pkg::TAPS; k++)
            begin
                if (cfg_index == c1d_pkg::REG_COEF_0 + c1d_pkg::CFG_IDX_W'(k))
                begin
                    coef_next[k] = cfg_data;
                end
            end
            if (cfg_index == c1d_pkg::REG_BIAS)
            begin
                bias_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
            bias_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
            bias_reg <= bias_next;
        end
    end

    // front: hold the window and turn each sample into a job
    c1d_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .q_stat  (q_stat),
        .push    (push),
        .job     (push_job),
        .fr_stat (fr_stat)
    );

    // decouple the two sides
    c1d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // back: advance through output positions and compute each word
    c1d_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_stat  (q_stat),
        .pop     (pop),
        .coef    (coef_reg),
        .bias    (bias_reg),
        .results (results)
    );

    // queue never holds more jobs than it has room for
    `C1D_ASSERT_NOW(a_q_bound, 1'b1,
        q_stat.count <= c1d_pkg::QCNT_W'(c1d_pkg::QDEPTH), "queue overfilled")

    // a pushed job is still waiting, or being worked, in the next cycle
    `C1D_ASSERT_NEXT(a_push_held, push, !q_stat.empty, "pushed job lost")

    // a frame end restarts the fill count
    `C1D_ASSERT_NEXT(a_frame_restart,
        samples.valid && samples.ready && samples.frame_end,
        fr_stat.fill == '0, "fill count not cleared at frame end")

endmodule

// ===== bench/tb_conv1d_same_pad_relu.sv =====
// ----------------------------------------------------------------------------
// tb_conv1d_same_pad_relu
// Self-checking bench for the seven-tap convolution filter with ReLU: a
// clocked driver and monitor, a local filter model, random idling on both
// sides and one long hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_conv1d_same_pad_relu;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_SH      = 14;      // Q1.14 coefficients
    localparam int SETTLE       = 16;      // queue plus six pipeline stages, with margin
    localparam int HOLD_CYCLES  = 60;      // long receiver hold-off
    localparam int IDLE_LIMIT   = 1000;    // watchdog: cycles with no word moving
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_ITEMS = 42;      // per random phase
    localparam int RANDOM_SETS  = 5;

    typedef struct {
        logic signed [c1d_pkg::SAMPLE_W-1:0] smp;
        logic                                fe;
    } sample_word_t;

    typedef struct packed {
        logic [c1d_pkg::VALUE_W-1:0] value;
        logic                        last;
    } result_word_t;

    typedef longint padded_t [2*c1d_pkg::TAPS];

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [c1d_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [c1d_pkg::CFG_W-1:0]     cfg_data;

    c1d_in_if  samp_if ();
    c1d_out_if res_if ();

    // filter model state
    logic signed [c1d_pkg::COEF_W-1:0]   tap_coef [c1d_pkg::TAPS];
    logic signed [c1d_pkg::COEF_W-1:0]   bias_reg;
    logic signed [c1d_pkg::SAMPLE_W-1:0] past_smp [c1d_pkg::WIN] = '{default: '0};
    logic [c1d_pkg::FILL_W-1:0]          fill_lvl = '0;

    sample_word_t sample_feed_q [$];
    result_word_t relu_out_q [$];

    // idling controls, set by the main sequence at the falling edge; hold_ack by the monitor
    bit snd_calm;
    bit rcv_calm;
    int hold_req;
    int hold_ack;

    int gap_left;
    int stall_left;
    int idle_cycles;

    int samples_taken;
    int frames_sent;
    int words_checked;
    int filter_sets;
    int fail_cnt;

    conv1d_same_pad_relu u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samp_if),
        .results   (res_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Filter model
    // ------------------------------------------------------------------------

    // One output point: taps over ext[start .. start+TAPS-1], bias, ReLU,
    // round to Q4.11 and clip at the top of the 15-bit range.
    function automatic logic [c1d_pkg::VALUE_W-1:0] conv_tap_sum(input padded_t ext,
                                                                 input int start);
        longint acc;
        acc = longint'(bias_reg) <<< FRAC_SH;
        for (int k = 0; k < c1d_pkg::TAPS; k++)
            acc += ext[start + k] * longint'(tap_coef[k]);
        if (acc <= 0)
            return '0;
        acc = (acc + (longint'(1) <<< (FRAC_SH - 1))) >>> FRAC_SH;
        if (acc > c1d_pkg::VALUE_MAX)
            acc = c1d_pkg::VALUE_MAX;
        return acc[c1d_pkg::VALUE_W-1:0];
    endfunction

    // Advance the model by one accepted sample and queue the words it causes.
    function automatic void filter_sample(input logic signed [c1d_pkg::SAMPLE_W-1:0] smp,
                                          input logic fe);
        padded_t ext;
        int      n;
        int      j;
        n = int'(fill_lvl);
        for (int i = 0; i < 2*c1d_pkg::TAPS; i++)
            ext[i] = 0;
        for (int i = 0; i < c1d_pkg::WIN; i++)
            ext[i] = longint'(past_smp[i]);
        ext[c1d_pkg::WIN] = longint'(smp);
        if (!fe)
        begin
            // no word until the lag is covered
            if (n >= c1d_pkg::LAG)
                relu_out_q.push_back('{conv_tap_sum(ext, 0), 1'b0});
            for (int i = 0; i < c1d_pkg::WIN; i++)
                past_smp[i] = ext[i + 1][c1d_pkg::SAMPLE_W-1:0];
            if (n < c1d_pkg::WIN)
                fill_lvl = fill_lvl + 1'b1;
        end
        else
        begin
            // flush the trailing points against zero padding
            j = (n >= c1d_pkg::LAG) ? 0 : c1d_pkg::LAG - n;
            for (; j <= c1d_pkg::LAG; j++)
                relu_out_q.push_back('{conv_tap_sum(ext, j), (j == c1d_pkg::LAG)});
            for (int i = 0; i < c1d_pkg::WIN; i++)
                past_smp[i] = '0;
            fill_lvl = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Random choices
    // ------------------------------------------------------------------------

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (snd_calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic int receiver_stall();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 3);
    endfunction

    function automatic int pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        if (r < 30)
            return int'($urandom_range(0, 128)) - 64;
        return int'($signed(16'($urandom)));
    endfunction

    function automatic int pick_coef();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            case ($urandom_range(0, 2))
                0: return -32768;
                1: return 32767;
                default: return 0;
            endcase
        end
        if (r < 60)
            return int'($urandom_range(0, 16384)) - 8192;
        return int'($signed(16'($urandom)));
    endfunction

    function automatic int pick_frame_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return $urandom_range(1, 3);
        if (r < 80)
            return $urandom_range(4, 12);
        return $urandom_range(13, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Sample driver: present the next queued word once the slot is free.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        sample_word_t nxt;
        if (!rst_n)
        begin
            samp_if.valid     <= 1'b0;
            samp_if.sample    <= '0;
            samp_if.frame_end <= 1'b0;
            gap_left          <= 0;
        end
        else
        begin
            if (samp_if.valid && samp_if.ready)
            begin
                filter_sample(samp_if.sample, samp_if.frame_end);
                samples_taken++;
            end
            if (!samp_if.valid || samp_if.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left      <= gap_left - 1;
                    samp_if.valid <= 1'b0;
                end
                else if (sample_feed_q.size() != 0)
                begin
                    nxt = sample_feed_q.pop_front();
                    samp_if.valid     <= 1'b1;
                    samp_if.sample    <= nxt.smp;
                    samp_if.frame_end <= nxt.fe;
                    gap_left          <= sender_gap();
                end
                else
                begin
                    samp_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each word against the oldest expectation, then
    // decide ready for the next cycle. A pending hold request wins over the
    // random stalls.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
            hold_ack     <= 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (relu_out_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("%0t ns: unexpected word value=%0d last=%0b",
                                 $time, res_if.value, res_if.last);
                end
                else
                begin
                    want = relu_out_q.pop_front();
                    words_checked++;
                    if (want.value !== res_if.value || want.last !== res_if.last)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX)
                            $display({"%0t ns: word %0d mismatch: value exp %0d got %0d,",
                                      " last exp %0b got %0b"},
                                     $time, words_checked, want.value, res_if.value,
                                     want.last, res_if.last);
                    end
                end
            end
            if (hold_req != hold_ack)
            begin
                hold_ack     <= hold_req;
                stall_left   <= HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left   <= stall_left - 1;
                res_if.ready <= 1'b0;
            end
            else if (!rcv_calm && $urandom_range(0, 99) < 20)
            begin
                stall_left   <= receiver_stall() - 1;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: give up when no word has moved on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (samp_if.valid && samp_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t ns: watchdog expired, %0d words still expected",
                     $time, relu_out_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------------

    task automatic queue_sample(input int v, input bit fe);
        sample_word_t w;
        w.smp = v[c1d_pkg::SAMPLE_W-1:0];
        w.fe  = fe;
        sample_feed_q.push_back(w);
        if (fe)
            frames_sent++;
    endtask

    // Write every tap and the bias, then drop the write enable.
    task automatic load_filter(input int taps_v[c1d_pkg::TAPS], input int bias_v);
        for (int k = 0; k <= c1d_pkg::TAPS; k++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            if (k == c1d_pkg::TAPS)
            begin
                cfg_index <= c1d_pkg::REG_BIAS;
                cfg_data  <= bias_v[c1d_pkg::CFG_W-1:0];
                bias_reg   = bias_v[c1d_pkg::COEF_W-1:0];
            end
            else
            begin
                cfg_index   <= c1d_pkg::REG_COEF_0 + c1d_pkg::CFG_IDX_W'(k);
                cfg_data    <= taps_v[k][c1d_pkg::CFG_W-1:0];
                tap_coef[k]  = taps_v[k][c1d_pkg::COEF_W-1:0];
            end
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        filter_sets++;
        @(negedge clk);
    endtask

    // Hold until every queued sample is taken and every expected word is
    // back, then let the pipeline empty before anything else changes.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_feed_q.size() != 0 || samp_if.valid || relu_out_q.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int taps_v [c1d_pkg::TAPS];
        int bias_v;
        int left;
        int len;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        snd_calm          = 1'b0;
        rcv_calm          = 1'b0;
        hold_req          = 0;
        for (int k = 0; k < c1d_pkg::TAPS; k++)
            tap_coef[k] = '0;
        bias_reg = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers still at reset: every word must come out as zero.
        queue_sample(1234, 1'b0);
        queue_sample(-5, 1'b1);
        wait_drained();

        // Centre tap at unity: output follows the input, negatives clamp to
        // zero. Single-sample frames, a short frame, a frame of exactly lag
        // plus one, and a longer frame with the sample extremes.
        for (int k = 0; k < c1d_pkg::TAPS; k++)
            taps_v[k] = (k == c1d_pkg::LEFT) ? 16384 : 0;
        load_filter(taps_v, 0);
        queue_sample(32767, 1'b1);
        queue_sample(-32768, 1'b1);
        queue_sample(1, 1'b0);
        queue_sample(-1, 1'b1);
        queue_sample(100, 1'b0);
        queue_sample(200, 1'b0);
        queue_sample(300, 1'b0);
        queue_sample(400, 1'b1);
        queue_sample(32767, 1'b0);
        queue_sample(-32768, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(-1, 1'b0);
        queue_sample(21845, 1'b0);
        queue_sample(-21846, 1'b1);
        wait_drained();

        // Most negative taps and top bias: saturation, then a ReLU clamp.
        for (int k = 0; k < c1d_pkg::TAPS; k++)
            taps_v[k] = -32768;
        load_filter(taps_v, 32767);
        for (int i = 0; i < 4; i++)
            queue_sample(-32768, i == 3);
        queue_sample(32767, 1'b1);
        wait_drained();

        // Most positive taps and bottom bias on a short frame.
        for (int k = 0; k < c1d_pkg::TAPS; k++)
            taps_v[k] = 32767;
        load_filter(taps_v, -32768);
        for (int i = 0; i < 3; i++)
            queue_sample(32767, i == 2);
        wait_drained();

        // Random filters over well-formed frames of random length. The last
        // set runs with the sender flat out while the result side holds off.
        for (int p = 0; p < RANDOM_SETS; p++)
        begin
            for (int k = 0; k < c1d_pkg::TAPS; k++)
                taps_v[k] = pick_coef();
            bias_v = pick_coef();
            load_filter(taps_v, bias_v);
            if (p == RANDOM_SETS - 1)
            begin
                snd_calm = 1'b1;
                rcv_calm = 1'b0;
                hold_req++;
            end
            else
            begin
                snd_calm = ($urandom_range(0, 3) == 0);
                rcv_calm = ($urandom_range(0, 3) == 0);
            end
            left = RANDOM_ITEMS;
            while (left > 0)
            begin
                len = pick_frame_len();
                for (int i = 0; i < len && left > 0; i++)
                begin
                    queue_sample(pick_sample(), i == len - 1 || left == 1);
                    left--;
                end
            end
            wait_drained();
        end

        if (relu_out_q.size() != 0)
            $display("%0d expected words never arrived", relu_out_q.size());

        $display("Run covered %0d samples in %0d frames under %0d filter settings",
                 samples_taken, frames_sent, filter_sets);
        $display("%0d result words checked, %0d failures", words_checked, fail_cnt);
        if (fail_cnt == 0 && relu_out_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
